### hdl/hpmc_pkg.sv
// shared types, command codes and helpers for the half-pel row predictor
package hpmc_pkg;

	localparam int NUM_PIX   = 16;
	localparam int REF_BYTES = NUM_PIX + 1;
	localparam int HALF_PIX  = NUM_PIX / 2;

	typedef enum logic [1:0] {
		CMD_COPY   = 2'd0,
		CMD_HALF_H = 2'd1,
		CMD_AVG_AB = 2'd2,
		CMD_QUAD   = 2'd3
	} cmd_t;

	typedef logic [7:0] pix_t;
	typedef logic [8:0] sum_t;

	// per-output-byte partial sums built in the sum stage
	typedef struct packed {
		pix_t a0;
		sum_t ha;
		sum_t hb;
		sum_t ab;
	} lane_t;

	// control that travels alongside the pixel data
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] left_off;
	} ctrl_t;

	// 8x8-block layout: 8 bytes per row, lower blocks 128 bytes on
	function automatic logic [7:0] left_offset_of(input logic [3:0] row);
		return {row[3], 1'b0, row[2:0], 3'b000};
	endfunction

	// left offset never has bit 6 set, so adding 64 is setting it
	function automatic logic [7:0] right_offset_of(input logic [7:0] loff);
		return loff | 8'h40;
	endfunction

endpackage

### hdl/half_pel_motion_comp_row.sv
// top level of the half-pel motion compensation row predictor
// One prediction row per beat: a row is taken at every clock edge with start high, and its
// 16 predicted bytes and the two destination offsets appear after the three register stages
// (input capture, pairwise sums, rounding and mode select), marked by done for exactly one
// cycle. Throughput is one row per cycle in every mode. busy is always low, so start alone
// governs acceptance, and the receiver must take each result in the cycle it is shown.
module half_pel_motion_comp_row (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [3:0]  row,
	input  logic [63:0] ref_a_lo,
	input  logic [63:0] ref_a_hi,
	input  logic [7:0]  ref_a_extra,
	input  logic [63:0] ref_b_lo,
	input  logic [63:0] ref_b_hi,
	input  logic [7:0]  ref_b_extra,
	output logic        done,
	output logic [63:0] left_pixels,
	output logic [63:0] right_pixels,
	output logic [7:0]  left_offset,
	output logic [7:0]  right_offset
);

	logic accept;

	hpmc_pkg::pix_t [hpmc_pkg::REF_BYTES-1:0] a_d;
	hpmc_pkg::pix_t [hpmc_pkg::REF_BYTES-1:0] b_d;
	hpmc_pkg::pix_t [hpmc_pkg::REF_BYTES-1:0] a_s1;
	hpmc_pkg::pix_t [hpmc_pkg::REF_BYTES-1:0] b_s1;
	hpmc_pkg::ctrl_t                          ctrl_s1;
	logic                                     vld_s1;

	logic                                     vld_s2;
	hpmc_pkg::ctrl_t                          ctrl_s2;
	hpmc_pkg::lane_t [hpmc_pkg::NUM_PIX-1:0]  lane_s2;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		for (int j = 0; j < hpmc_pkg::HALF_PIX; j++) begin
			a_d[j]                      = ref_a_lo[63 - 8*j -: 8];
			a_d[j + hpmc_pkg::HALF_PIX] = ref_a_hi[63 - 8*j -: 8];
			b_d[j]                      = ref_b_lo[63 - 8*j -: 8];
			b_d[j + hpmc_pkg::HALF_PIX] = ref_b_hi[63 - 8*j -: 8];
		end
		a_d[hpmc_pkg::REF_BYTES-1] = ref_a_extra;
		b_d[hpmc_pkg::REF_BYTES-1] = ref_b_extra;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		a_s1             <= a_d;
		b_s1             <= b_d;
		ctrl_s1.cmd      <= hpmc_pkg::cmd_t'(cmd);
		ctrl_s1.left_off <= hpmc_pkg::left_offset_of(row);
	end

	hpmc_sum u_sum (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s1  (vld_s1),
		.ctrl_s1 (ctrl_s1),
		.a_s1    (a_s1),
		.b_s1    (b_s1),
		.vld_s2  (vld_s2),
		.ctrl_s2 (ctrl_s2),
		.lane_s2 (lane_s2)
	);

	hpmc_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_s2   (vld_s2),
		.ctrl_s2  (ctrl_s2),
		.lane_s2  (lane_s2),
		.vld_s3   (done),
		.left_s3  (left_pixels),
		.right_s3 (right_pixels),
		.loff_s3  (left_offset),
		.roff_s3  (right_offset)
	);

	// every accepted row produces a result after the capture, sum and round registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 done)
		else $error("accepted row did not produce a result after three cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 3))
		else $error("result shown without a matching accepted row");

	a_offsets: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (right_offset == left_offset + 8'h40) && (left_offset[2:0] == 3'b000))
		else $error("destination offsets inconsistent");

	a_copy: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(accept && (cmd == hpmc_pkg::CMD_COPY), 3) |->
			(left_pixels == $past(ref_a_lo, 3)) && (right_pixels == $past(ref_a_hi, 3)))
		else $error("copy mode altered reference bytes");

endmodule

### hdl/hpmc_sum.sv
// second stage: neighbor and cross-reference sums for every output byte
module hpmc_sum (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         vld_s1,
	input  hpmc_pkg::ctrl_t                              ctrl_s1,
	input  hpmc_pkg::pix_t [hpmc_pkg::REF_BYTES-1:0]     a_s1,
	input  hpmc_pkg::pix_t [hpmc_pkg::REF_BYTES-1:0]     b_s1,
	output logic                                         vld_s2,
	output hpmc_pkg::ctrl_t                              ctrl_s2,
	output hpmc_pkg::lane_t [hpmc_pkg::NUM_PIX-1:0]      lane_s2
);

	hpmc_pkg::lane_t [hpmc_pkg::NUM_PIX-1:0] lane_d;

	always_comb begin
		for (int j = 0; j < hpmc_pkg::NUM_PIX; j++) begin
			lane_d[j].a0 = a_s1[j];
			lane_d[j].ha = {1'b0, a_s1[j]} + {1'b0, a_s1[j+1]};
			lane_d[j].hb = {1'b0, b_s1[j]} + {1'b0, b_s1[j+1]};
			lane_d[j].ab = {1'b0, a_s1[j]} + {1'b0, b_s1[j]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctrl_s2 <= ctrl_s1;
		lane_s2 <= lane_d;
	end

endmodule

### hdl/hpmc_round.sv
// third stage: mode select, rounding and packing into the output halves
module hpmc_round (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     vld_s2,
	input  hpmc_pkg::ctrl_t                          ctrl_s2,
	input  hpmc_pkg::lane_t [hpmc_pkg::NUM_PIX-1:0]  lane_s2,
	output logic                                     vld_s3,
	output logic [63:0]                              left_s3,
	output logic [63:0]                              right_s3,
	output logic [7:0]                               loff_s3,
	output logic [7:0]                               roff_s3
);

	hpmc_pkg::pix_t [hpmc_pkg::NUM_PIX-1:0] pix;
	logic [63:0] left_d;
	logic [63:0] right_d;

	always_comb begin
		logic [9:0]  half_sum;
		logic [9:0]  avg_sum;
		logic [10:0] quad_sum;
		half_sum = '0;
		avg_sum  = '0;
		quad_sum = '0;
		for (int j = 0; j < hpmc_pkg::NUM_PIX; j++) begin
			half_sum = {1'b0, lane_s2[j].ha} + 10'd1;
			avg_sum  = {1'b0, lane_s2[j].ab} + 10'd1;
			quad_sum = {2'b00, lane_s2[j].ha} + {2'b00, lane_s2[j].hb} + 11'd2;
			case (ctrl_s2.cmd)
				hpmc_pkg::CMD_COPY:   pix[j] = lane_s2[j].a0;
				hpmc_pkg::CMD_HALF_H: pix[j] = half_sum[8:1];
				hpmc_pkg::CMD_AVG_AB: pix[j] = avg_sum[8:1];
				hpmc_pkg::CMD_QUAD:   pix[j] = quad_sum[9:2];
				default:              pix[j] = lane_s2[j].a0;
			endcase
		end
	end

	// byte 0 of each half sits in the top bits
	always_comb begin
		for (int j = 0; j < hpmc_pkg::HALF_PIX; j++) begin
			left_d[63 - 8*j -: 8]  = pix[j];
			right_d[63 - 8*j -: 8] = pix[j + hpmc_pkg::HALF_PIX];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		left_s3  <= left_d;
		right_s3 <= right_d;
		loff_s3  <= ctrl_s2.left_off;
		roff_s3  <= hpmc_pkg::right_offset_of(ctrl_s2.left_off);
	end

endmodule

### tb/half_pel_motion_comp_row_tb.sv
// self-checking testbench for the half-pel motion compensation row predictor
`timescale 1ns / 100ps

module half_pel_motion_comp_row_tb;

	typedef struct packed {
		hpmc_pkg::cmd_t cmd;
		logic [3:0]     row;
		logic [63:0]    a_lo;
		logic [63:0]    a_hi;
		logic [7:0]     a_ex;
		logic [63:0]    b_lo;
		logic [63:0]    b_hi;
		logic [7:0]     b_ex;
	} row_req_t;

	typedef struct packed {
		logic [63:0] left;
		logic [63:0] right;
		logic [7:0]  loff;
		logic [7:0]  roff;
	} row_pred_t;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	hpmc_pkg::cmd_t cmd;
	logic [3:0]     row;
	logic [63:0]    ref_a_lo;
	logic [63:0]    ref_a_hi;
	logic [7:0]     ref_a_extra;
	logic [63:0]    ref_b_lo;
	logic [63:0]    ref_b_hi;
	logic [7:0]     ref_b_extra;
	logic           done;
	logic [63:0]    left_pixels;
	logic [63:0]    right_pixels;
	logic [7:0]     left_offset;
	logic [7:0]     right_offset;

	row_pred_t expected_rows[$];
	int        rows_sent;
	int        rows_checked;
	int        mismatch_cnt;

	half_pel_motion_comp_row u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.row          (row),
		.ref_a_lo     (ref_a_lo),
		.ref_a_hi     (ref_a_hi),
		.ref_a_extra  (ref_a_extra),
		.ref_b_lo     (ref_b_lo),
		.ref_b_hi     (ref_b_hi),
		.ref_b_extra  (ref_b_extra),
		.done         (done),
		.left_pixels  (left_pixels),
		.right_pixels (right_pixels),
		.left_offset  (left_offset),
		.right_offset (right_offset)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("[half_pel_motion_comp_row] ERROR");
		$finish;
	end

	// 16 predicted bytes plus the 8x8-block destination offsets of both halves
	function automatic row_pred_t predict_row(row_req_t q);
		logic [7:0] a [0:16];
		logic [7:0] b [0:16];
		int         s;
		int         lo;
		row_pred_t  p;
		for (int j = 0; j < 8; j++) begin
			a[j]     = q.a_lo[63 - 8 * j -: 8];
			a[j + 8] = q.a_hi[63 - 8 * j -: 8];
			b[j]     = q.b_lo[63 - 8 * j -: 8];
			b[j + 8] = q.b_hi[63 - 8 * j -: 8];
		end
		a[16] = q.a_ex;
		b[16] = q.b_ex;
		p = '0;
		for (int j = 0; j < 16; j++) begin
			case (q.cmd)
				hpmc_pkg::CMD_COPY:   s = int'(a[j]);
				hpmc_pkg::CMD_HALF_H: s = (int'(a[j]) + int'(a[j + 1]) + 1) >> 1;
				hpmc_pkg::CMD_AVG_AB: s = (int'(a[j]) + int'(b[j]) + 1) >> 1;
				default:              s = (int'(a[j]) + int'(b[j]) + int'(a[j + 1])
					+ int'(b[j + 1]) + 2) >> 2;
			endcase
			if (j < 8)
				p.left[63 - 8 * j -: 8] = s[7:0];
			else
				p.right[63 - 8 * (j - 8) -: 8] = s[7:0];
		end
		lo = 8 * (q.row % 8) + ((q.row >= 8) ? 128 : 0);
		p.loff = lo[7:0];
		p.roff = 8'(lo + 64);
		return p;
	endfunction

	task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatch_cnt++;
	endtask

	// results cannot be held off, so every done beat is checked as it shows
	always @(posedge clk) begin : check_results
		row_pred_t want;
		if (arst_n && done) begin
			if (expected_rows.size() == 0) begin
				flag_mismatch("result with no row pending", left_pixels, '0);
			end else begin
				want = expected_rows.pop_front();
				rows_checked++;
				if (left_pixels !== want.left)
					flag_mismatch("left_pixels", left_pixels, want.left);
				if (right_pixels !== want.right)
					flag_mismatch("right_pixels", right_pixels, want.right);
				if (left_offset !== want.loff)
					flag_mismatch("left_offset", 64'(left_offset), 64'(want.loff));
				if (right_offset !== want.roff)
					flag_mismatch("right_offset", 64'(right_offset), 64'(want.roff));
			end
		end
	end

	task automatic send_row(row_req_t q);
		@(negedge clk);
		start       <= 1'b1;
		cmd         <= q.cmd;
		row         <= q.row;
		ref_a_lo    <= q.a_lo;
		ref_a_hi    <= q.a_hi;
		ref_a_extra <= q.a_ex;
		ref_b_lo    <= q.b_lo;
		ref_b_hi    <= q.b_hi;
		ref_b_extra <= q.b_ex;
		do @(posedge clk); while (busy);
		expected_rows.push_back(predict_row(q));
		rows_sent++;
	endtask

	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	function automatic logic [63:0] rand_ref_word();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// all-zero and all-ones references in every mode, at the first and last row
	task automatic test_extremes();
		row_req_t q;
		for (int c = 0; c < 4; c++) begin
			q = '{cmd: hpmc_pkg::cmd_t'(c), row: 4'd0, default: '0};
			send_row(q);
			q = '{cmd: hpmc_pkg::cmd_t'(c), row: 4'd15, a_lo: '1, a_hi: '1, a_ex: '1,
				b_lo: '1, b_hi: '1, b_ex: '1};
			send_row(q);
		end
	endtask

	// odd sums that exercise round-half-up, with every middle row's offsets
	task automatic test_rounding_and_rows();
		logic [63:0] pat [0:3];
		row_req_t    q;
		int          k;
		pat[0] = 64'h0100_0100_0100_0100;
		pat[1] = 64'hFF00_FF00_FF00_FF00;
		pat[2] = 64'h7F80_817E_0001_FEFF;
		pat[3] = 64'h0102_0304_0506_0708;
		for (int r = 1; r < 15; r++) begin
			k = r / 4;
			q.cmd  = hpmc_pkg::cmd_t'(r % 4);
			q.row  = 4'(r);
			q.a_lo = pat[k % 4];
			q.a_hi = pat[(k + 1) % 4];
			q.b_lo = pat[(k + 2) % 4];
			q.b_hi = ~pat[(k + 3) % 4];
			q.a_ex = 8'(r * 17);
			q.b_ex = ~q.a_ex;
			send_row(q);
		end
	endtask

	task automatic test_random_stream(int n, int idle_pct);
		row_req_t q;
		repeat (n) begin
			if ($urandom_range(99) < idle_pct)
				idle_cycles($urandom_range(1, 6));
			q.cmd  = hpmc_pkg::cmd_t'($urandom_range(3));
			q.row  = 4'($urandom_range(15));
			q.a_lo = rand_ref_word();
			q.a_hi = rand_ref_word();
			q.a_ex = 8'($urandom_range(255));
			q.b_lo = rand_ref_word();
			q.b_hi = rand_ref_word();
			q.b_ex = 8'($urandom_range(255));
			send_row(q);
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = hpmc_pkg::CMD_COPY;
		row          = '0;
		ref_a_lo     = '0;
		ref_a_hi     = '0;
		ref_a_extra  = '0;
		ref_b_lo     = '0;
		ref_b_hi     = '0;
		ref_b_extra  = '0;
		rows_sent    = 0;
		rows_checked = 0;
		mismatch_cnt = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_rounding_and_rows();
		test_random_stream(500, 0);
		test_random_stream(500, 49);
		test_random_stream(500, 14);
		test_random_stream(500, 0);
		idle_cycles(1);

		while (expected_rows.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		$display("sent %0d rows: extremes, rounding cases, all rows, random streams with gaps",
			rows_sent);
		$display("checked %0d results, %0d mismatches", rows_checked, mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("[half_pel_motion_comp_row] OK");
		else
			$display("[half_pel_motion_comp_row] ERROR");
		$finish;
	end

endmodule
